### hw/rtl/scsa_pkg.sv
// shared constants and types of the slab allocator
`default_nettype none
package scsa_pkg;
    localparam int unsigned NumPagesDefault = 64;
    localparam int unsigned AddrW           = 18;
    localparam int unsigned SizeW           = 16;
    localparam int unsigned ClassW          = 3;
    localparam int unsigned SlotW           = 7;
    localparam int unsigned CountW          = 8;
    localparam int unsigned TotalW          = 14;
    localparam int unsigned NumClasses      = 7;
    localparam int unsigned PageShift       = 12;
    localparam int unsigned OffW            = 12;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StTooBig  = 2'd1;
    localparam logic [1:0] StNoPages = 2'd2;
    localparam logic [1:0] StBadFree = 2'd3;

    localparam logic OpAlloc = 1'b0;
    localparam logic OpFree  = 1'b1;

    // size to class, sizes above 2048 flagged separately
    function automatic logic [ClassW-1:0] size_to_class(input logic [SizeW-1:0] sz);
        logic [ClassW-1:0] c;
        c = 3'd0;
        if (sz > 16'd1024)     c = 3'd6;
        else if (sz > 16'd512) c = 3'd5;
        else if (sz > 16'd256) c = 3'd4;
        else if (sz > 16'd128) c = 3'd3;
        else if (sz > 16'd64)  c = 3'd2;
        else if (sz > 16'd32)  c = 3'd1;
        return c;
    endfunction

    // slots in a page of a class: 128 >> class
    function automatic logic [CountW-1:0] class_slots(input logic [ClassW-1:0] c);
        return 8'd128 >> c;
    endfunction
endpackage
`default_nettype wire

### hw/rtl/scsa_link_ram.sv
// synchronous memory, one write and one registered read per cycle
`default_nettype none
module scsa_link_ram #(
    parameter int unsigned AW = 13,
    parameter int unsigned DW = scsa_pkg::SlotW
) (
    input  wire               i_clk,
    input  wire               i_we,
    input  wire [AW-1:0]      i_waddr,
    input  wire [DW-1:0]      i_wdata,
    input  wire [AW-1:0]      i_raddr,
    output logic [DW-1:0]     o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/size_class_slab_allocator_unit.sv
// slab allocator top level: sequencer, page tables and link memory
//
// channel  dir  fields (low bit first)
// s_axis   in   tuser: op ; tdata: request_size[15:0], object_address[33:16], zero pad
// m_axis   out  tdata: granted_address[17:0], status[19:18], zero pad
//
// a too-large allocate goes straight to the output; a free reads the page table
// entry, then checks and pushes; an allocate from a page in use searches the page
// table (the search reads one page table entry per cycle); an allocate that opens
// a page makes one link write per slot; and an allocate with the pool used up
// reports no pages after the search. reset is synchronous, no clearing
// pass; the input is not ready from acceptance until the result word leaves m_axis.
`default_nettype none
module size_class_slab_allocator_unit #(
    parameter int unsigned NUM_PAGES = scsa_pkg::NumPagesDefault
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [39:0]  s_axis_tdata,  // request_size, object_address
    input  wire         s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata   // granted_address, status
);
    localparam int unsigned PW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int unsigned PCW = $clog2(NUM_PAGES + 1);
    localparam int unsigned LAW = PW + scsa_pkg::SlotW;
    localparam int unsigned PTW = scsa_pkg::ClassW + scsa_pkg::SlotW + scsa_pkg::CountW;

    localparam logic [2:0] SIdle   = 3'd0;
    localparam logic [2:0] SSearch = 3'd1;
    localparam logic [2:0] SLink   = 3'd2;
    localparam logic [2:0] SPopRd  = 3'd3;
    localparam logic [2:0] SPopWt  = 3'd4;
    localparam logic [2:0] SPop    = 3'd5;
    localparam logic [2:0] SOut    = 3'd6;
    localparam logic [2:0] SFree   = 3'd7;

    logic [2:0] r_state, n_state;
    logic [PCW-1:0] r_taken, n_taken;
    logic [PW-1:0] r_pg, n_pg;
    logic [scsa_pkg::ClassW-1:0] r_cls, n_cls;
    logic [scsa_pkg::SlotW-1:0] r_k, n_k;
    logic [scsa_pkg::AddrW-1:0] r_gaddr, n_gaddr;
    logic [1:0] r_status, n_status;
    logic [scsa_pkg::OffW-1:0] r_off, n_off;
    logic r_fok, n_fok;
    logic [scsa_pkg::TotalW-1:0] r_total [scsa_pkg::NumClasses];

    logic [scsa_pkg::SlotW-1:0] w_link_rd;
    logic w_we;
    logic [LAW-1:0] w_waddr;
    logic [scsa_pkg::SlotW-1:0] w_wdata;

    // page table entry: {class, list head, free count}, registered read of n_pg
    logic w_pt_we;
    logic [PTW-1:0] w_pt_wdata;
    logic [PTW-1:0] w_pt_rd;
    logic [scsa_pkg::ClassW-1:0] w_rd_cls;
    logic [scsa_pkg::SlotW-1:0]  w_rd_head;
    logic [scsa_pkg::CountW-1:0] w_rd_count;
    logic w_tot_we;
    logic [scsa_pkg::TotalW-1:0] w_tot_val;

    logic w_acc;
    logic [scsa_pkg::SizeW-1:0] w_size;
    logic [scsa_pkg::AddrW-1:0] w_faddr;
    logic [5:0] w_fpg_hi;
    logic [scsa_pkg::OffW-1:0] w_off;
    logic [scsa_pkg::SlotW-1:0] w_fslot;
    logic [scsa_pkg::OffW-1:0] w_mask;
    logic [scsa_pkg::CountW-1:0] w_nslots;

    scsa_link_ram #(.AW(LAW), .DW(scsa_pkg::SlotW)) u_link (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr ({r_pg, w_rd_head}),
        .o_rdata (w_link_rd)
    );

    scsa_link_ram #(.AW(PW), .DW(PTW)) u_page (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (r_pg),
        .i_wdata (w_pt_wdata),
        .i_raddr (n_pg),
        .o_rdata (w_pt_rd)
    );

    assign {w_rd_cls, w_rd_head, w_rd_count} = w_pt_rd;

    assign s_axis_tready = (r_state == SIdle);
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_size  = s_axis_tdata[15:0];
    assign w_faddr = s_axis_tdata[33:16];
    assign w_fpg_hi = w_faddr[17:12];
    assign w_off   = w_faddr[scsa_pkg::OffW-1:0];
    assign w_mask  = 12'((32 << w_rd_cls) - 1);
    assign w_fslot = scsa_pkg::SlotW'(r_off >> ({1'b0, w_rd_cls} + 4'd5));
    assign w_nslots = scsa_pkg::class_slots(r_cls);

    assign m_axis_tvalid = (r_state == SOut);
    assign m_axis_tdata  = {4'd0, r_status, r_gaddr};

    // sequencer
    always_comb begin
        n_state = r_state; n_taken = r_taken; n_pg = r_pg; n_cls = r_cls;
        n_k = r_k; n_gaddr = r_gaddr; n_status = r_status;
        n_off = r_off; n_fok = r_fok;
        w_we = 1'b0; w_waddr = {r_pg, r_k}; w_wdata = '0;
        w_pt_we = 1'b0; w_pt_wdata = '0;
        w_tot_we = 1'b0; w_tot_val = '0;
        case (r_state)
            SIdle: begin
                if (w_acc) begin
                    n_gaddr = '0;
                    n_state = SOut;
                    if (s_axis_tuser == scsa_pkg::OpAlloc) begin
                        if (w_size > 16'd2048) begin
                            n_status = scsa_pkg::StTooBig;
                        end else begin
                            n_cls = scsa_pkg::size_to_class(w_size);
                            n_pg = '0;
                            n_state = SSearch;
                        end
                    end else begin
                        // read the page entry, check it next cycle
                        n_status = scsa_pkg::StBadFree;
                        n_pg = PW'(w_fpg_hi);
                        n_off = w_off;
                        n_fok = (32'(w_fpg_hi) < 32'(r_taken));
                        n_state = SFree;
                    end
                end
            end
            SFree: begin
                if (r_fok && 32'(w_rd_cls) < scsa_pkg::NumClasses
                    && (r_off & w_mask) == '0 && w_fslot != '0) begin
                    // push slot back on its page list
                    n_status = scsa_pkg::StOk;
                    n_cls = w_rd_cls;
                    w_we = 1'b1;
                    w_waddr = {r_pg, w_fslot};
                    w_wdata = w_rd_head;
                    w_pt_we = 1'b1;
                    w_pt_wdata = {w_rd_cls, w_fslot, w_rd_count + 8'd1};
                    w_tot_we = 1'b1;
                    w_tot_val = r_total[w_rd_cls] + 14'd1;
                end
                n_state = SOut;
            end
            SSearch: begin
                if (PCW'(r_pg) < r_taken && !(PCW'(r_pg) == PCW'(NUM_PAGES))) begin
                    if (w_rd_cls == r_cls && w_rd_count != '0) begin
                        n_state = SPopRd;
                    end else if (PCW'(r_pg) + 1'b1 < r_taken) begin
                        n_pg = r_pg + 1'b1;
                    end else if (r_taken == PCW'(NUM_PAGES)) begin
                        n_status = scsa_pkg::StNoPages;
                        n_state = SOut;
                    end else begin
                        n_pg = PW'(r_taken);
                        n_k = 7'd1;
                        n_state = SLink;
                    end
                end else if (r_taken == PCW'(NUM_PAGES)) begin
                    n_status = scsa_pkg::StNoPages;
                    n_state = SOut;
                end else begin
                    n_pg = PW'(r_taken);
                    n_k = 7'd1;
                    n_state = SLink;
                end
            end
            SLink: begin
                // link slot k to k-1, one slot per cycle
                w_we = 1'b1;
                w_waddr = {r_pg, r_k};
                w_wdata = r_k - 7'd1;
                n_k = r_k + 7'd1;
                if (8'(r_k) == w_nslots - 8'd1) begin
                    n_taken = r_taken + 1'b1;
                    w_pt_we = 1'b1;
                    w_pt_wdata = {r_cls, r_k, w_nslots - 8'd1};
                    w_tot_we = 1'b1;
                    w_tot_val = r_total[r_cls] + 14'(w_nslots) - 14'd1;
                    n_state = SPopRd;
                end
            end
            // page entry and then link word settle before the pop
            SPopRd: n_state = SPopWt;
            SPopWt: n_state = SPop;
            SPop: begin
                w_pt_we = 1'b1;
                w_pt_wdata = {r_cls, w_link_rd, w_rd_count - 8'd1};
                w_tot_we = 1'b1;
                w_tot_val = r_total[r_cls] - 14'd1;
                n_status = scsa_pkg::StOk;
                n_gaddr = scsa_pkg::AddrW'(
                          (scsa_pkg::AddrW'(r_pg) << scsa_pkg::PageShift)
                          + (scsa_pkg::AddrW'(w_rd_head) << ({1'b0, r_cls} + 4'd5)));
                n_state = SOut;
            end
            SOut: begin
                if (m_axis_tready) n_state = SIdle;
            end
            default: n_state = SIdle;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIdle;
            r_taken <= '0;
            for (int i = 0; i < scsa_pkg::NumClasses; i++) r_total[i] <= '0;
        end else begin
            r_state <= n_state;
            r_taken <= n_taken;
            if (w_tot_we) r_total[n_cls] <= w_tot_val;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_pg <= n_pg;
        r_cls <= n_cls;
        r_k <= n_k;
        r_gaddr <= n_gaddr;
        r_status <= n_status;
        r_off <= n_off;
        r_fok <= n_fok;
    end
endmodule
`default_nettype wire

### tb/tb_size_class_slab_allocator_unit.sv
// testbench of the slab allocator: directed and random allocate/free words against a predictor
`default_nettype none
module tb_size_class_slab_allocator_unit;

    localparam int NPages = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    wire         s_axis_tready;
    logic [39:0] s_axis_tdata;   // request_size[15:0], object_address[33:16], zero pad
    logic        s_axis_tuser;   // op
    wire         m_axis_tvalid;
    logic        m_axis_tready;
    wire  [23:0] m_axis_tdata;   // granted_address[17:0], status[19:18], zero pad

    size_class_slab_allocator_unit #(.NUM_PAGES(NPages)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    typedef struct packed {
        logic [scsa_pkg::AddrW-1:0] addr;
        logic [1:0]                 status;
    } t_grant;

    // predictor state
    int unsigned                  taken_pages;
    logic [scsa_pkg::ClassW-1:0]  pg_class [NPages];
    logic [scsa_pkg::SlotW-1:0]   pg_head  [NPages];
    logic [scsa_pkg::CountW-1:0]  pg_count [NPages];
    logic [scsa_pkg::SlotW-1:0]   link_mem [NPages*128];
    logic [scsa_pkg::TotalW-1:0]  class_total [scsa_pkg::NumClasses];

    t_grant      grants_due[$];
    logic [17:0] live_objs[$];
    int          fail_cnt;
    int          sent_cnt;
    int          got_cnt;
    int          status_seen[4];
    bit          idle_on;
    bit          rx_hold;

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    // model of one word
    function automatic t_grant allocator_predict(input logic op, input logic [15:0] sz,
                                                 input logic [17:0] oaddr);
        t_grant g;
        int unsigned cls, pg, slot, n, off;
        bit found;
        g = '0;
        found = 0;
        if (op == scsa_pkg::OpAlloc) begin
            if (sz > 16'd2048) begin
                g.status = scsa_pkg::StTooBig;
                return g;
            end
            cls = 0;
            if (sz > 1024) cls = 6;
            else if (sz > 512) cls = 5;
            else if (sz > 256) cls = 4;
            else if (sz > 128) cls = 3;
            else if (sz > 64) cls = 2;
            else if (sz > 32) cls = 1;
            for (pg = 0; pg < taken_pages; pg++) begin
                if (pg_class[pg] == cls && pg_count[pg] != 0) begin
                    found = 1;
                    break;
                end
            end
            if (!found) begin
                if (taken_pages >= NPages) begin
                    g.status = scsa_pkg::StNoPages;
                    return g;
                end
                pg = taken_pages;
                taken_pages++;
                n = 4096 >> (cls + 5);
                pg_class[pg] = scsa_pkg::ClassW'(cls);
                link_mem[pg*128+1] = '0;
                for (int k = 2; k < n; k++) link_mem[pg*128+k] = scsa_pkg::SlotW'(k - 1);
                pg_head[pg] = scsa_pkg::SlotW'(n - 1);
                pg_count[pg] = scsa_pkg::CountW'(n - 1);
                class_total[cls] = scsa_pkg::TotalW'(32'(class_total[cls]) + n - 1);
            end
            slot = 32'(pg_head[pg]);
            pg_head[pg] = link_mem[pg*128+slot];
            pg_count[pg] = pg_count[pg] - 8'd1;
            class_total[cls] = class_total[cls] - 14'd1;
            g.addr = scsa_pkg::AddrW'((pg << 12) + (slot << (cls + 5)));
            g.status = scsa_pkg::StOk;
        end else begin
            pg = 32'(oaddr) >> 12;
            off = 32'(oaddr) & 32'hfff;
            g.status = scsa_pkg::StBadFree;
            if (pg >= taken_pages) return g;
            cls = 32'(pg_class[pg]);
            if ((off & ((32 << cls) - 1)) != 0) return g;
            slot = off >> (cls + 5);
            if (slot == 0) return g;
            link_mem[pg*128+slot] = pg_head[pg];
            pg_head[pg] = scsa_pkg::SlotW'(slot);
            pg_count[pg] = pg_count[pg] + 8'd1;
            class_total[cls] = class_total[cls] + 14'd1;
            g.status = scsa_pkg::StOk;
        end
        return g;
    endfunction

    // send one word, idling at random before it
    task automatic send_word(input logic op, input logic [15:0] sz, input logic [17:0] oaddr);
        t_grant g;
        while (idle_on && $urandom_range(99) < 22) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, oaddr, sz};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        g = allocator_predict(op, sz, oaddr);
        grants_due.push_back(g);
        if (op == scsa_pkg::OpAlloc && g.status == scsa_pkg::StOk) live_objs.push_back(g.addr);
        sent_cnt++;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic alloc_word(input logic [15:0] sz);
        send_word(scsa_pkg::OpAlloc, sz, 18'($urandom));
    endtask

    task automatic free_word(input logic [17:0] a);
        send_word(scsa_pkg::OpFree, 16'($urandom), a);
    endtask

    task automatic drain_wait();
        while (grants_due.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= !rx_hold && !(idle_on && $urandom_range(99) < 22);
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_cnt++;
            if (grants_due.size() == 0) begin
                $error("result with nothing expected: %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                g = grants_due.pop_front();
                status_seen[g.status]++;
                if (m_axis_tdata[19:18] !== g.status) begin
                    $error("status: expected %0d actual %0d", g.status, m_axis_tdata[19:18]);
                    fail_cnt++;
                end
                if (m_axis_tdata[17:0] !== g.addr) begin
                    $error("granted_address: expected %h actual %h", g.addr,
                           m_axis_tdata[17:0]);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic test_directed();
        alloc_word(16'd0);
        alloc_word(16'd32);
        alloc_word(16'd33);
        alloc_word(16'd64);
        alloc_word(16'd65);
        alloc_word(16'd129);
        alloc_word(16'd257);
        alloc_word(16'd513);
        alloc_word(16'd1025);
        alloc_word(16'd2048);
        alloc_word(16'd2049);
        alloc_word(16'hffff);
        free_word(18'h3ffff);              // page never taken
        free_word(18'h00000);              // slot zero
        free_word(18'h00021);              // misaligned
        free_word(18'h01020);              // class 1 page, not a multiple of 64
        free_word(live_objs[0]);
        free_word(live_objs[0]);           // double free goes through
        alloc_word(16'd1);
        alloc_word(16'd1);
        drain_wait();
    endtask

    // random allocates and frees: mostly valid frees of live objects, some random addresses
    task automatic test_random(input int n);
        int idx;
        logic [15:0] sz;
        for (int i = 0; i < n; i++) begin
            if (i == n / 3) idle_on = 0;
            if (i == n / 2) idle_on = 1;
            if ($urandom_range(99) < 45 && live_objs.size() != 0) begin
                if ($urandom_range(9) == 0) free_word(18'($urandom));
                else begin
                    idx = int'($urandom_range(live_objs.size() - 1));
                    free_word(live_objs[idx]);
                    live_objs.delete(idx);
                end
            end else begin
                case ($urandom_range(9))
                    0: sz = 16'($urandom);
                    1: sz = 16'(1024 + $urandom_range(1024));
                    default: sz = 16'($urandom_range(600));
                endcase
                alloc_word(sz);
            end
        end
    endtask

    // hold the receiver while words keep coming, then pause until drained
    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1;
                repeat (400) @(posedge i_clk);
                rx_hold = 0;
            end
            begin
                for (int i = 0; i < 6; i++) alloc_word(16'($urandom_range(2048)));
            end
        join
        drain_wait();
    endtask

    // use up the page pool
    task automatic test_exhaust();
        for (int i = 0; i < 70; i++) alloc_word(16'd2048);
        alloc_word(16'd1500);
        drain_wait();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        fail_cnt = 0;
        sent_cnt = 0;
        got_cnt = 0;
        idle_on = 1;
        rx_hold = 0;
        taken_pages = 0;
        for (int c = 0; c < scsa_pkg::NumClasses; c++) class_total[c] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1100);
        test_exhaust();
        test_random(150);
        drain_wait();
        repeat (300) @(posedge i_clk);
        $display("covered %0d words, %0d results: ok %0d, too large %0d,",
                 sent_cnt, got_cnt, status_seen[0], status_seen[1]);
        $display("no pages %0d, bad free %0d, pages taken %0d of %0d",
                 status_seen[2], status_seen[3], taken_pages, NPages);
        if (fail_cnt == 0 && grants_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
hw/rtl/scsa_pkg.sv
hw/rtl/scsa_link_ram.sv
hw/rtl/size_class_slab_allocator_unit.sv
tb/tb_size_class_slab_allocator_unit.sv
